// ----- sv/twt_pkg.sv -----
// package: shared types and constants for the task watchdog table
`timescale 1ns / 1ps

package twt_pkg;

   localparam int TABLE_SLOTS_DEF = 16;
   localparam int TASK_W          = 16;
   localparam int TIME_W          = 32;
   localparam int CSR_IDX_W       = 2;
   localparam int CSR_DATA_W      = 32;
   localparam int ACT_W           = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLED = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT = CSR_IDX_W'(1);

   localparam logic [TIME_W-1:0] TIMEOUT_RST = TIME_W'(1000);

   typedef enum logic [1:0] {
      REQ_REGISTER   = 2'd0,
      REQ_UNREGISTER = 2'd1,
      REQ_FEED       = 2'd2,
      REQ_QUERY      = 2'd3
   } req_kind_type;

   typedef enum logic [ACT_W-1:0] {
      ACT_NONE   = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_KICK   = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_EVAL,
      ST_DONE
   } state_type;

endpackage

// ----- sv/task_watchdog_table_core.sv -----
// top level: task watchdog table with slot ram, scan sequencer and csr port
//
// usage:
//  - csr port: csr_valid/csr_ready with csr_index and csr_wdata; index 0 is
//    enabled (bit 0), index 1 is timeout_ms; other indexes are ignored.
//    csr_ready is always high; write only while the block is idle.
//  - request: an item is taken at a clock edge with start high and busy low.
//  - response: one item per request, shown for one cycle with rsp_valid high.
//  - timing: the slot ram is scanned one entry per cycle through its single
//    read port in the scan state, the drain state checks the last word read,
//    then the eval and done states evaluate and write back. the response
//    strobe is registered from the done state; busy stays high from the
//    accept until then, so a new item is taken only once the previous one
//    is through, at the earliest while its response strobe is high.
//  - reset: clears the slot in-use bits, the count, enabled and sets
//    timeout_ms to 1000; slot contents are read in every slot but only used in slots marked in use.
//  - the receiver cannot stall; the response is dropped if not taken.
`timescale 1ns / 1ps

module task_watchdog_table_core #(
   parameter int TABLE_SLOTS = twt_pkg::TABLE_SLOTS_DEF,
   parameter int CNT_W = $clog2(TABLE_SLOTS + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [twt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [twt_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       req_type,
   input  logic [twt_pkg::TASK_W-1:0]       req_task_id,
   input  logic [twt_pkg::TIME_W-1:0]       req_now_ms,
   input  logic [twt_pkg::TIME_W-1:0]       req_margin_ms,
   input  logic                             req_backend_ok,
   output logic                             rsp_valid,
   output logic                             rsp_ok,
   output logic [twt_pkg::ACT_W-1:0]        rsp_backend_action,
   output logic [CNT_W-1:0]                 rsp_registered_count
);

   import twt_pkg::*;

   localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int ENT_W = TASK_W + TIME_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

   state_type state_ff, state_in;

   logic              enabled_ff;
   logic [TIME_W-1:0] timeout_ff;

   logic [TABLE_SLOTS-1:0] used_ff, used_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   req_kind_type      kind_ff;
   logic [TASK_W-1:0] task_ff;
   logic [TIME_W-1:0] now_ff;
   logic [TIME_W-1:0] margin_ff;
   logic              bok_ff;

   logic [IDX_W-1:0]  addr_ff;
   logic              chk_valid_ff;
   logic [IDX_W-1:0]  chk_addr_ff;
   logic              match_ff;
   logic [IDX_W-1:0]  match_idx_ff;
   logic [TIME_W-1:0] match_feed_ff;
   logic              free_ff;
   logic [IDX_W-1:0]  free_idx_ff;

   logic              margin_ge_ff;
   logic [TIME_W-1:0] thresh_ff;
   logic [TIME_W-1:0] elapsed_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_ok_ff, rsp_ok_in;
   action_type        rsp_act_ff, rsp_act_in;
   logic [CNT_W-1:0]  rsp_cnt_ff;

   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   logic [ENT_W-1:0]  ram_wr_data;
   logic              ram_rd_en;
   logic [ENT_W-1:0]  ram_rd_data;
   logic [TASK_W-1:0] rd_task;
   logic [TIME_W-1:0] rd_feed;
   logic              accept;
   logic              last_addr;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign last_addr = (addr_ff == LAST_IDX);
   assign ram_rd_en = (state_ff == ST_SCAN);
   assign rd_task   = ram_rd_data[ENT_W-1:TIME_W];
   assign rd_feed   = ram_rd_data[TIME_W-1:0];

   twt_ram #(
      .WIDTH (ENT_W),
      .DEPTH (TABLE_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (addr_ff),
      .rd_data (ram_rd_data)
   );

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
         timeout_ff <= TIMEOUT_RST;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_ENABLED) begin
            enabled_ff <= csr_wdata[0];
         end else if (csr_index == CSR_TIMEOUT) begin
            timeout_ff <= csr_wdata[TIME_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         chk_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         chk_valid_ff <= ram_rd_en;
      end
   end

   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_ok_in    = 1'b0;
      rsp_act_in   = ACT_NONE;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = free_idx_ff;
      ram_wr_data  = {task_ff, {TIME_W{1'b0}}};
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (last_addr) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            unique case (kind_ff)
               REQ_REGISTER: begin
                  if (enabled_ff && task_ff != '0 && !match_ff && bok_ff && free_ff) begin
                     rsp_ok_in            = 1'b1;
                     ram_wr_en            = 1'b1;
                     used_in[free_idx_ff] = 1'b1;
                     count_in             = count_ff + CNT_W'(1);
                  end
               end
               REQ_UNREGISTER: begin
                  if (enabled_ff && task_ff != '0 && match_ff) begin
                     rsp_ok_in             = 1'b1;
                     rsp_act_in            = ACT_REMOVE;
                     used_in[match_idx_ff] = 1'b0;
                     count_in              = count_ff - CNT_W'(1);
                  end
               end
               REQ_FEED: begin
                  if (enabled_ff) begin
                     rsp_ok_in   = 1'b1;
                     rsp_act_in  = ACT_KICK;
                     ram_wr_en   = match_ff;
                     ram_wr_addr = match_idx_ff;
                     ram_wr_data = {task_ff, now_ff};
                  end
               end
               REQ_QUERY: begin
                  rsp_ok_in = match_ff && (margin_ge_ff || (elapsed_ff >= thresh_ff));
               end
            endcase
         end
      endcase
   end

   // request capture, scan bookkeeping, query arithmetic and response capture
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff   <= req_kind_type'(req_type);
         task_ff   <= req_task_id;
         now_ff    <= req_now_ms;
         margin_ff <= req_margin_ms;
         bok_ff    <= req_backend_ok;
         addr_ff   <= '0;
         match_ff  <= 1'b0;
         free_ff   <= 1'b0;
      end else begin
         if (ram_rd_en && !last_addr) begin
            addr_ff <= addr_ff + IDX_W'(1);
         end
         if (chk_valid_ff) begin
            if (used_ff[chk_addr_ff] && rd_task == task_ff) begin
               match_ff      <= 1'b1;
               match_idx_ff  <= chk_addr_ff;
               match_feed_ff <= rd_feed;
            end
            if (!used_ff[chk_addr_ff] && !free_ff) begin
               free_ff     <= 1'b1;
               free_idx_ff <= chk_addr_ff;
            end
         end
      end
      chk_addr_ff <= addr_ff;
      if (state_ff == ST_EVAL) begin
         margin_ge_ff <= (margin_ff >= timeout_ff);
         thresh_ff    <= timeout_ff - margin_ff;
         elapsed_ff   <= now_ff - match_feed_ff;
      end
      if (state_ff == ST_DONE) begin
         rsp_ok_ff  <= rsp_ok_in;
         rsp_act_ff <= rsp_act_in;
         rsp_cnt_ff <= count_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_ok               = rsp_ok_ff;
   assign rsp_backend_action   = rsp_act_ff;
   assign rsp_registered_count = rsp_cnt_ff;

   a_count_matches_used: assert property (@(posedge clock) disable iff (reset)
      count_ff == CNT_W'($countones(used_ff)))
      else $error("slot count differs from in-use bits");

   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ST_DONE))
      else $error("response without finished request");

   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SCAN) && (addr_ff == '0))
      else $error("accepted item did not start the scan");

   a_match_is_used: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && match_ff) |-> used_ff[match_idx_ff])
      else $error("matched slot is not in use");

   a_free_is_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && free_ff) |-> !used_ff[free_idx_ff])
      else $error("free slot is in use");

endmodule

// ----- sv/twt_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps

module twt_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- dv/twt_checker.sv -----
// checker for the task watchdog table: mirrors the slot table and compares every response
`timescale 1ns / 1ps

module twt_checker #(
   parameter int TABLE_SLOTS = twt_pkg::TABLE_SLOTS_DEF,
   parameter int CNT_W = $clog2(TABLE_SLOTS + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [twt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [twt_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           start,
   input  logic                           busy,
   input  logic [1:0]                     req_type,
   input  logic [twt_pkg::TASK_W-1:0]     req_task_id,
   input  logic [twt_pkg::TIME_W-1:0]     req_now_ms,
   input  logic [twt_pkg::TIME_W-1:0]     req_margin_ms,
   input  logic                           req_backend_ok,
   input  logic                           rsp_valid,
   input  logic                           rsp_ok,
   input  logic [twt_pkg::ACT_W-1:0]      rsp_backend_action,
   input  logic [CNT_W-1:0]               rsp_registered_count,
   output int                             fail_count,
   output int                             pending_count,
   output int                             checked_count,
   output int                             full_rejects
);

   import twt_pkg::*;

   typedef struct packed {
      logic             ok;
      action_type       action;
      logic [CNT_W-1:0] count;
   } outcome_type;

   logic              slot_used [TABLE_SLOTS];
   logic [TASK_W-1:0] slot_task [TABLE_SLOTS];
   logic [TIME_W-1:0] slot_feed [TABLE_SLOTS];
   logic [CNT_W-1:0]  live_count;
   logic              wd_enabled;
   logic [TIME_W-1:0] wd_timeout;
   outcome_type       expected_q[$];

   int mismatches = 0;
   int compared   = 0;
   int full_seen  = 0;

   task automatic clear_table();
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         slot_used[i] = 1'b0;
         slot_task[i] = '0;
         slot_feed[i] = '0;
      end
      live_count = '0;
      wd_enabled = 1'b0;
      wd_timeout = TIMEOUT_RST;
   endtask

   function automatic int find_slot(logic [TASK_W-1:0] id);
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         if (slot_used[i] && slot_task[i] == id) return i;
      end
      return -1;
   endfunction

   function automatic outcome_type predict_outcome(req_kind_type kind, logic [TASK_W-1:0] id,
                                                   logic [TIME_W-1:0] now,
                                                   logic [TIME_W-1:0] margin, logic bok);
      outcome_type       res;
      int                hit;
      int                free_slot;
      logic [TIME_W-1:0] elapsed;
      res.ok     = 1'b0;
      res.action = ACT_NONE;
      hit        = find_slot(id);
      case (kind)
         REQ_REGISTER: begin
            if (wd_enabled && id != '0 && hit < 0 && bok) begin
               free_slot = -1;
               for (int i = 0; i < TABLE_SLOTS; i++) begin
                  if (!slot_used[i] && free_slot < 0) free_slot = i;
               end
               if (free_slot >= 0) begin
                  slot_used[free_slot] = 1'b1;
                  slot_task[free_slot] = id;
                  slot_feed[free_slot] = '0;
                  live_count++;
                  res.ok = 1'b1;
               end else begin
                  full_seen++;
               end
            end
         end
         REQ_UNREGISTER: begin
            if (wd_enabled && id != '0 && hit >= 0) begin
               slot_used[hit] = 1'b0;
               slot_task[hit] = '0;
               if (live_count != '0) live_count--;
               res.ok     = 1'b1;
               res.action = ACT_REMOVE;
            end
         end
         REQ_FEED: begin
            if (wd_enabled) begin
               if (hit >= 0) slot_feed[hit] = now;
               res.ok     = 1'b1;
               res.action = ACT_KICK;
            end
         end
         default: begin
            if (hit >= 0) begin
               if (margin >= wd_timeout) begin
                  res.ok = 1'b1;
               end else begin
                  elapsed = now - slot_feed[hit];
                  res.ok  = (elapsed >= wd_timeout - margin);
               end
            end
         end
      endcase
      res.count = live_count;
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("%0t ns: response %s is %0d, should be %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         clear_table();
         expected_q.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               report_mismatch("strobe with nothing pending, ok", rsp_ok, 0);
            end else begin
               want = expected_q.pop_front();
               compared++;
               if (rsp_ok !== want.ok) report_mismatch("ok", rsp_ok, want.ok);
               if (rsp_backend_action !== want.action)
                  report_mismatch("backend_action", rsp_backend_action, want.action);
               if (rsp_registered_count !== want.count)
                  report_mismatch("registered_count", rsp_registered_count, want.count);
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_ENABLED) wd_enabled = csr_wdata[0];
            else if (csr_index == CSR_TIMEOUT) wd_timeout = csr_wdata;
         end
         if (start && !busy)
            expected_q.push_back(predict_outcome(req_kind_type'(req_type), req_task_id,
                                                 req_now_ms, req_margin_ms, req_backend_ok));
      end
      fail_count    <= mismatches;
      pending_count <= expected_q.size();
      checked_count <= compared;
      full_rejects  <= full_seen;
   end

endmodule

// ----- dv/tb_top.sv -----
// testbench top for the task watchdog table: drives requests and csr writes, gives the verdict
`timescale 1ns / 1ps

module tb_top;
   import twt_pkg::*;

   localparam int SLOTS = TABLE_SLOTS_DEF;
   localparam int CNT_W = $clog2(SLOTS + 1);

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_ENABLED;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  start = 1'b0;
   logic                  busy;
   logic [1:0]            req_type = REQ_QUERY;
   logic [TASK_W-1:0]     req_task_id = '0;
   logic [TIME_W-1:0]     req_now_ms = '0;
   logic [TIME_W-1:0]     req_margin_ms = '0;
   logic                  req_backend_ok = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ok;
   logic [ACT_W-1:0]      rsp_backend_action;
   logic [CNT_W-1:0]      rsp_registered_count;

   int fail_count;
   int pending_count;
   int checked_count;
   int full_rejects;

   int                items_sent = 0;
   int                settings_used = 0;
   bit                quiet = 1'b0;
   logic [TIME_W-1:0] clk_ms = '0;
   logic [TIME_W-1:0] cur_timeout = TIMEOUT_RST;
   logic [TASK_W-1:0] id_pool [32];
   int                pool_size = 1;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task_watchdog_table_core #(.TABLE_SLOTS(SLOTS)) dut (
      .clock, .reset, .csr_valid, .csr_ready, .csr_index, .csr_wdata,
      .start, .busy, .req_type, .req_task_id, .req_now_ms, .req_margin_ms,
      .req_backend_ok, .rsp_valid, .rsp_ok, .rsp_backend_action, .rsp_registered_count
   );

   twt_checker #(.TABLE_SLOTS(SLOTS)) table_check (
      .clock, .reset, .csr_valid, .csr_ready, .csr_index, .csr_wdata,
      .start, .busy, .req_type, .req_task_id, .req_now_ms, .req_margin_ms,
      .req_backend_ok, .rsp_valid, .rsp_ok, .rsp_backend_action, .rsp_registered_count,
      .fail_count, .pending_count, .checked_count, .full_rejects
   );

   task automatic send_request(req_kind_type kind, logic [TASK_W-1:0] id,
                               logic [TIME_W-1:0] now, logic [TIME_W-1:0] margin,
                               logic bok);
      req_type       <= kind;
      req_task_id    <= id;
      req_now_ms     <= now;
      req_margin_ms  <= margin;
      req_backend_ok <= bok;
      start          <= 1'b1;
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   task automatic idle_gap();
      int r;
      int n;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return;
      n = (r < 90) ? $urandom_range(1, 24) : $urandom_range(25, 150);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic setup_watchdog(logic en, logic [TIME_W-1:0] tmo);
      csr_index <= CSR_ENABLED;
      csr_wdata <= {{(CSR_DATA_W-1){1'b0}}, en};
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_TIMEOUT;
      csr_wdata <= tmo;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      cur_timeout = tmo;
      settings_used++;
   endtask

   task automatic random_request();
      req_kind_type      kind;
      logic [TASK_W-1:0] id;
      logic [TIME_W-1:0] now;
      logic [TIME_W-1:0] margin;
      logic [TIME_W-1:0] step;
      int                r;
      r = $urandom_range(0, 99);
      kind = (r < 35) ? REQ_REGISTER : (r < 50) ? REQ_UNREGISTER :
             (r < 75) ? REQ_FEED : REQ_QUERY;
      id = ($urandom_range(0, 9) == 0) ? TASK_W'($urandom) :
           id_pool[$urandom_range(0, pool_size - 1)];
      step = (cur_timeout >> 3) + 1;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         clk_ms = clk_ms + $urandom_range(0, step);
         now = clk_ms;
      end else if (r < 85) begin
         now = $urandom;
      end else begin
         now = clk_ms;
      end
      r = $urandom_range(0, 99);
      margin = (r < 50) ? $urandom_range(0, cur_timeout) : (r < 75) ? $urandom : '0;
      send_request(kind, id, now, margin, $urandom_range(0, 9) != 0);
   endtask

   initial begin
      logic              en;
      logic [TIME_W-1:0] tmo;
      int                count;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // disabled after reset
      send_request(REQ_REGISTER, 16'd5, 32'd0, 32'd0, 1'b1);
      idle_gap();
      send_request(REQ_FEED, 16'd5, 32'd10, 32'd0, 1'b1);
      idle_gap();
      send_request(REQ_UNREGISTER, 16'd5, 32'd20, 32'd0, 1'b1);
      idle_gap();
      send_request(REQ_QUERY, 16'd5, 32'd30, 32'd0, 1'b1);
      wait_drained();
      setup_watchdog(1'b1, 32'd1000);
      send_request(REQ_REGISTER, 16'h0000, 32'd0, 32'd0, 1'b1);
      idle_gap();
      send_request(REQ_REGISTER, 16'hFFFF, 32'd0, 32'd0, 1'b0);
      idle_gap();
      send_request(REQ_REGISTER, 16'hFFFF, 32'd0, 32'd0, 1'b1);
      idle_gap();
      send_request(REQ_REGISTER, 16'hFFFF, 32'd0, 32'd0, 1'b1);
      idle_gap();
      send_request(REQ_REGISTER, 16'h0001, 32'd0, 32'd0, 1'b1);
      idle_gap();
      send_request(REQ_QUERY, 16'hFFFF, 32'd999, 32'd0, 1'b0);
      idle_gap();
      send_request(REQ_QUERY, 16'hFFFF, 32'd1000, 32'd0, 1'b0);
      idle_gap();
      send_request(REQ_QUERY, 16'hFFFF, 32'd5, 32'd1000, 1'b0);
      idle_gap();
      send_request(REQ_QUERY, 16'hFFFF, 32'd5, 32'hFFFF_FFFF, 1'b0);
      idle_gap();
      send_request(REQ_FEED, 16'hFFFF, 32'hFFFF_FFFF, 32'd0, 1'b0);
      idle_gap();
      // elapsed wraps past zero
      send_request(REQ_QUERY, 16'hFFFF, 32'h0000_03E6, 32'd0, 1'b0);
      idle_gap();
      send_request(REQ_QUERY, 16'hFFFF, 32'h0000_03E7, 32'd0, 1'b0);
      idle_gap();
      send_request(REQ_FEED, 16'h0000, 32'd40, 32'd0, 1'b0);
      idle_gap();
      send_request(REQ_FEED, 16'h1234, 32'd50, 32'd0, 1'b0);
      idle_gap();
      send_request(REQ_QUERY, 16'h0000, 32'd60, 32'd0, 1'b0);
      idle_gap();
      send_request(REQ_UNREGISTER, 16'h0000, 32'd70, 32'd0, 1'b0);
      idle_gap();
      send_request(REQ_UNREGISTER, 16'h1234, 32'd80, 32'd0, 1'b0);
      idle_gap();
      send_request(REQ_UNREGISTER, 16'hFFFF, 32'd90, 32'd0, 1'b0);
      idle_gap();
      send_request(REQ_QUERY, 16'hFFFF, 32'd100, 32'd0, 1'b0);

      for (int phase = 0; phase < 6; phase++) begin
         wait_drained();
         en = 1'b1;
         case (phase)
            0: tmo = 32'd1;
            1: tmo = 32'hFFFF_FFFF;
            2: begin
               en  = 1'b0;
               tmo = $urandom_range(1, 5000);
            end
            default: begin
               tmo = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 2000) : $urandom;
               if (tmo == '0) tmo = 32'd1;
            end
         endcase
         setup_watchdog(en, tmo);
         quiet = (phase == 3);
         pool_size = $urandom_range(6, 24);
         for (int i = 0; i < pool_size; i++) begin
            id_pool[i] = ($urandom_range(0, 19) == 0) ? '0 : TASK_W'($urandom_range(1, 65535));
         end
         count = (phase == 2) ? 100 : 160;
         for (int k = 0; k < count; k++) begin
            random_request();
            if ($urandom_range(0, 49) == 0) wait_drained();
            else idle_gap();
         end
      end

      wait_drained();
      repeat (SLOTS + 8) @(posedge clock);
      $display("summary: %0d requests under %0d watchdog settings, %0d responses compared",
               items_sent, settings_used, checked_count);
      $display("summary: %0d registrations refused by a full table", full_rejects);
      if (fail_count == 0 && pending_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- task_watchdog_table_core.f -----
sv/twt_pkg.sv
sv/twt_ram.sv
sv/task_watchdog_table_core.sv
dv/twt_checker.sv
dv/tb_top.sv
